// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/qedm_pkg.sv =====
// ----------------------------------------------------------------------------
// qedm_pkg
// Types and constants for the quadrature edge decoder.
// ----------------------------------------------------------------------------
package qedm_pkg;

  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CountW     = 8;
  localparam logic [CountW-1:0] ConfirmEdgesReset = 8'd8;
  localparam logic [CountW-1:0] CountMax          = 8'hFF;

  typedef enum logic [1:0] {
    OP_EDGE_A     = 2'd0,
    OP_EDGE_B     = 2'd1,
    OP_SHIFT_UP   = 2'd2,
    OP_SHIFT_DOWN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_SLOW = 2'd1,
    MODE_FAST = 2'd2
  } mode_t;

  typedef enum logic [0:0] {
    REG_CONFIRM_EDGES = 1'b0
  } reg_idx_t;

  localparam logic signed [2:0] StepNone = 3'sd0;
  localparam logic signed [2:0] StepFwd  = 3'sd1;
  localparam logic signed [2:0] StepRev  = -3'sd1;
  localparam logic signed [2:0] StepSkip = 3'sd2;

  typedef struct packed {
    op_t  operation;
    logic a_level;
    logic b_level;
  } in_item_t;

  typedef struct packed {
    logic signed [2:0] position_step;
    logic              direction;
    mode_t             mode;
    logic              shift_busy;
    logic              is_up;
    logic              is_down;
  } out_item_t;

endpackage

// ===== rtl/core/quadrature_edge_decoder_modes_unit.sv =====
// ----------------------------------------------------------------------------
// quadrature_edge_decoder_modes_unit
// Quadrature edge decoder with init, slow and fast modes and shift control.
// ----------------------------------------------------------------------------
// Result: registered; valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless the output stalls; the decode is
//   one pass of logic between the state registers and the result register.
// Reset: synchronous, active low; state clears, confirm_edges returns to 8.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadrature_edge_decoder_modes_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  qedm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output qedm_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qedm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [qedm_pkg::CfgDataW-1:0]  pwdata,
  output logic [qedm_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import qedm_pkg::*;

  logic [CountW-1:0] confirm_edges_r;
  logic              dir_r, dir_nxt;
  logic              prev_a_r, prev_a_nxt;
  logic              prev_b_r, prev_b_nxt;
  logic              last_a_r, last_a_nxt;
  mode_t             mode_r, mode_nxt;
  logic              high_r, high_nxt;
  logic              slow_r, slow_nxt;
  logic              pend_r, pend_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CountW-1:0] count_inc;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              in_accept;
  logic              is_a;
  logic              is_edge;
  logic              shift_up;
  logic              busy;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[CfgAddrW-1]);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (cfg_idx == REG_CONFIRM_EDGES) ?
                     {{(CfgDataW-CountW){1'b0}}, confirm_edges_r} : '0;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_a      = (in_data.operation == OP_EDGE_A);
  assign is_edge   = (in_data.operation == OP_EDGE_A) || (in_data.operation == OP_EDGE_B);
  assign shift_up  = (in_data.operation == OP_SHIFT_UP);
  assign count_inc = (count_r == CountMax) ? count_r : count_r + 1'b1;

  // next state
  always_comb begin
    dir_nxt    = dir_r;
    prev_a_nxt = prev_a_r;
    prev_b_nxt = prev_b_r;
    last_a_nxt = last_a_r;
    mode_nxt   = mode_r;
    high_nxt   = high_r;
    slow_nxt   = slow_r;
    pend_nxt   = pend_r;
    count_nxt  = count_r;
    busy       = 1'b0;
    if (is_edge) begin
      last_a_nxt = is_a;
      unique case (mode_r)
        MODE_INIT: begin
          dir_nxt    = is_a ? (in_data.a_level ^ prev_b_r)
                            : ~(in_data.b_level ^ prev_a_r);
          prev_a_nxt = in_data.a_level;
          prev_b_nxt = in_data.b_level;
          count_nxt  = count_inc;
          if (!is_a && (count_inc >= confirm_edges_r)) begin
            count_nxt = '0;
            mode_nxt  = MODE_SLOW;
            slow_nxt  = 1'b1;
          end
        end
        MODE_SLOW: begin
          if (last_a_r == is_a) begin
            dir_nxt = ~dir_r;
          end
          if (pend_r) begin
            mode_nxt = MODE_FAST;
            pend_nxt = 1'b0;
          end
        end
        default: begin
          if (pend_r) begin
            mode_nxt = MODE_SLOW;
            pend_nxt = 1'b0;
          end
        end
      endcase
    end else if (shift_up) begin
      if (high_r) begin
        busy = 1'b0;
      end else if (pend_r) begin
        busy = 1'b1;
      end else if (slow_r) begin
        pend_nxt = 1'b1;
        slow_nxt = 1'b0;
        busy     = 1'b1;
      end else begin
        high_nxt = 1'b1;
      end
    end else begin
      if (slow_r) begin
        busy = 1'b0;
      end else if (pend_r) begin
        busy = 1'b1;
      end else if (high_r) begin
        pend_nxt = 1'b1;
        high_nxt = 1'b0;
        busy     = 1'b1;
      end else begin
        slow_nxt = 1'b1;
      end
    end
  end

  // result
  always_comb begin
    out_data_nxt.direction  = dir_nxt;
    out_data_nxt.mode       = mode_nxt;
    out_data_nxt.shift_busy = busy;
    out_data_nxt.is_up      = high_nxt && !pend_nxt;
    out_data_nxt.is_down    = slow_nxt && !pend_nxt;
    if (!is_edge) begin
      out_data_nxt.position_step = StepNone;
    end else if ((mode_r == MODE_INIT) || (mode_r == MODE_SLOW)) begin
      out_data_nxt.position_step = dir_nxt ? StepFwd : StepRev;
    end else begin
      out_data_nxt.position_step = (last_a_r == is_a) ? StepSkip : StepFwd;
    end
  end

  assign out_valid_nxt = in_accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_edges_r <= ConfirmEdgesReset;
      dir_r           <= 1'b0;
      prev_a_r        <= 1'b0;
      prev_b_r        <= 1'b0;
      last_a_r        <= 1'b0;
      mode_r          <= MODE_INIT;
      high_r          <= 1'b0;
      slow_r          <= 1'b0;
      pend_r          <= 1'b0;
      count_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_idx == REG_CONFIRM_EDGES)) begin
        confirm_edges_r <= pwdata[CountW-1:0];
      end
      if (in_accept) begin
        dir_r    <= dir_nxt;
        prev_a_r <= prev_a_nxt;
        prev_b_r <= prev_b_nxt;
        last_a_r <= last_a_nxt;
        mode_r   <= mode_nxt;
        high_r   <= high_nxt;
        slow_r   <= slow_nxt;
        pend_r   <= pend_nxt;
        count_r  <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_IMPLIES(a_pend_no_up, clk, rst_n, pend_r, !high_r, "shift pending with up flag set")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && out_stall, out_valid_r, "result dropped")
  `ASSERT_NEXT(a_no_reinit, clk, rst_n, mode_r != MODE_INIT, mode_r != MODE_INIT, "back in init")
  `ASSERT_IMPLIES(a_count_init, clk, rst_n, mode_r != MODE_INIT, count_r == '0, "count outside init")
  `ASSERT_NEXT(a_result, clk, rst_n, in_accept, out_valid_r, "accepted request gave no result")

endmodule
